@@ rtl/wear_level_page_selector_core_macros.svh @@
// ----------------------------------------------------------------------------
// Wear-level page selector assertion macros
// Shared concurrent assertion forms, sampled on aclk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef WEAR_LEVEL_PAGE_SELECTOR_CORE_MACROS_SVH
`define WEAR_LEVEL_PAGE_SELECTOR_CORE_MACROS_SVH

// Same-cycle implication.
`define WLPS_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WLPS_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/wlps_pkg.sv @@
// ----------------------------------------------------------------------------
// Wear-level page selector package
// Command codes, datapath operation codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package wlps_pkg;

    localparam logic [1:0] CMD_LOAD       = 2'd0;
    localparam logic [1:0] CMD_FIND_WRITE = 2'd1;
    localparam logic [1:0] CMD_FIND_READ  = 2'd2;
    localparam logic [1:0] CMD_MARK_BAD   = 2'd3;

    typedef logic [3:0] dp_op_t;

    localparam dp_op_t DP_NOP       = 4'd0;
    localparam dp_op_t DP_LOAD      = 4'd1;
    localparam dp_op_t DP_MARK      = 4'd2;
    localparam dp_op_t DP_START     = 4'd3;
    localparam dp_op_t DP_SCAN      = 4'd4;
    localparam dp_op_t DP_FREE_RD   = 4'd5;
    localparam dp_op_t DP_FREE_CALC = 4'd6;
    localparam dp_op_t DP_RD_LO     = 4'd7;
    localparam dp_op_t DP_RD_HI     = 4'd8;
    localparam dp_op_t DP_OVF       = 4'd9;
    localparam dp_op_t DP_NEW       = 4'd10;
    localparam dp_op_t DP_SKIP      = 4'd11;
    localparam dp_op_t DP_WFIN      = 4'd12;
    localparam dp_op_t DP_WALK      = 4'd13;
    localparam dp_op_t DP_OUT       = 4'd14;

    typedef struct packed {
        dp_op_t op;
        logic   write;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic free_hit;
        logic new_last;
        logic skip_done;
        logic walk_done;
    } dp_status_t;

endpackage

@@ rtl/wear_level_page_selector_core.sv @@
// Load-record and mark-bad beats are accepted back to back; they produce no
// result. A find beat walks the page table one page per cycle through the
// single read port of the sequence memory: find-write-slot with a free page
// skips the search for the newest page, otherwise find-write-slot runs the
// bad-page skip after that search and find-read-page the backward walk to a
// page whose CRC checked out. The result sits in an output register, so the
// next command is taken while it waits; a further find result waits until the
// previous one has been taken.
// ----------------------------------------------------------------------------
// Wear-level page selector core
// Keeps per-page CRC, sequence and bad records and picks write and read pages.
// ----------------------------------------------------------------------------
`include "wear_level_page_selector_core_macros.svh"

module wear_level_page_selector_core #(
    parameter int PAGES = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [3:0] s_page,
    input  logic       s_crc_good,
    input  logic [7:0] s_header_seq,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_chosen_page,
    output logic [4:0] m_slot_seq,
    output logic       m_found
);
    import wlps_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_st;

    wlps_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (dp_cmd),
        .st        (dp_st)
    );

    wlps_dp #(
        .PAGES (PAGES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (dp_cmd),
        .st            (dp_st),
        .s_page        (s_page),
        .s_crc_good    (s_crc_good),
        .s_header_seq  (s_header_seq),
        .m_chosen_page (m_chosen_page),
        .m_slot_seq    (m_slot_seq),
        .m_found       (m_found)
    );

    `WLPS_ASSERT_NEXT(a_find_holds_input, s_valid && s_ready && (s_command == CMD_FIND_WRITE || s_command == CMD_FIND_READ), !s_ready, "find beat did not take the block busy")
    `WLPS_ASSERT_NEXT(a_update_no_result, s_valid && s_ready && !m_valid && (s_command == CMD_LOAD || s_command == CMD_MARK_BAD), !m_valid, "load or mark-bad produced a result")
    `WLPS_ASSERT_NEXT(a_out_raises_valid, dp_cmd.op == DP_OUT, m_valid, "result load without valid")
    `WLPS_ASSERT_NOW(a_out_slot_free, dp_cmd.op == DP_OUT, !m_valid || m_ready, "result register overwritten while held")

endmodule

@@ rtl/wlps_ctrl.sv @@
// ----------------------------------------------------------------------------
// Wear-level page selector controller
// Sequences the page scans of the find commands and owns both handshakes.
// ----------------------------------------------------------------------------
module wlps_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [1:0]           s_command,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wlps_pkg::dp_cmd_t    cmd,
    input  wlps_pkg::dp_status_t st
);
    import wlps_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SCAN      = 4'd1;
    localparam logic [3:0] ST_FREE_RD   = 4'd2;
    localparam logic [3:0] ST_FREE_CALC = 4'd3;
    localparam logic [3:0] ST_RD_LO     = 4'd4;
    localparam logic [3:0] ST_RD_HI     = 4'd5;
    localparam logic [3:0] ST_OVF       = 4'd6;
    localparam logic [3:0] ST_NEW       = 4'd7;
    localparam logic [3:0] ST_SKIP      = 4'd8;
    localparam logic [3:0] ST_WFIN      = 4'd9;
    localparam logic [3:0] ST_WALK      = 4'd10;
    localparam logic [3:0] ST_OUT       = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       write_reg, write_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        write_next   = write_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd.op       = DP_NOP;
        cmd.write    = (s_command == CMD_FIND_WRITE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_command)
                        CMD_LOAD:     cmd.op = DP_LOAD;
                        CMD_MARK_BAD: cmd.op = DP_MARK;
                        CMD_FIND_WRITE, CMD_FIND_READ: begin
                            cmd.op     = DP_START;
                            write_next = (s_command == CMD_FIND_WRITE);
                            state_next = ST_SCAN;
                        end
                        default: cmd.op = DP_NOP;
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.op = DP_SCAN;
                if (st.scan_last) begin
                    state_next = (write_reg && st.free_hit) ? ST_FREE_RD : ST_RD_LO;
                end
            end
            ST_FREE_RD: begin
                cmd.op     = DP_FREE_RD;
                state_next = ST_FREE_CALC;
            end
            ST_FREE_CALC: begin
                cmd.op     = DP_FREE_CALC;
                state_next = ST_OUT;
            end
            ST_RD_LO: begin
                cmd.op     = DP_RD_LO;
                state_next = ST_RD_HI;
            end
            ST_RD_HI: begin
                cmd.op     = DP_RD_HI;
                state_next = ST_OVF;
            end
            ST_OVF: begin
                cmd.op     = DP_OVF;
                state_next = ST_NEW;
            end
            ST_NEW: begin
                cmd.op = DP_NEW;
                if (st.new_last) begin
                    state_next = write_reg ? ST_SKIP : ST_WALK;
                end
            end
            ST_SKIP: begin
                cmd.op = DP_SKIP;
                if (st.skip_done) begin
                    state_next = ST_WFIN;
                end
            end
            ST_WFIN: begin
                cmd.op     = DP_WFIN;
                state_next = ST_OUT;
            end
            ST_WALK: begin
                cmd.op = DP_WALK;
                if (st.walk_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = DP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            write_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            write_reg   <= write_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ rtl/wlps_dp.sv @@
// ----------------------------------------------------------------------------
// Wear-level page selector datapath
// Page records, sequence memory, scan counters and the result register.
// ----------------------------------------------------------------------------
module wlps_dp #(
    parameter int PAGES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wlps_pkg::dp_cmd_t    cmd,
    output wlps_pkg::dp_status_t st,
    input  logic [3:0]           s_page,
    input  logic                 s_crc_good,
    input  logic [7:0]           s_header_seq,
    output logic [3:0]           m_chosen_page,
    output logic [4:0]           m_slot_seq,
    output logic                 m_found
);
    import wlps_pkg::*;

    localparam int IW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW = $clog2(PAGES + 1);
    localparam logic [CW-1:0] P_C    = CW'(PAGES);
    localparam logic [CW-1:0] LAST_C = CW'(PAGES - 1);
    localparam logic [8:0]    P9     = 9'(PAGES);
    localparam logic [8:0]    P2_9   = 9'(2 * PAGES);
    localparam logic [8:0]    P2M1_9 = 9'(2 * PAGES - 1);
    localparam logic [7:0]    P8     = 8'(PAGES);

    logic [7:0]      seq_mem [PAGES];
    logic [7:0]      rd_data_reg;
    logic [IW-1:0]   rd_idx_reg;
    logic [IW-1:0]   rd_addr;
    logic            mem_we;

    logic [PAGES-1:0] valid_reg, valid_next;
    logic [PAGES-1:0] bad_reg, bad_next;

    logic [CW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   lo_reg, lo_next;
    logic [IW-1:0]   hi_reg, hi_next;
    logic            any_reg, any_next;
    logic            free_hit_reg, free_hit_next;
    logic [IW-1:0]   free_idx_reg, free_idx_next;
    logic            write_reg, write_next;
    logic [7:0]      seq_lo_reg, seq_lo_next;
    logic [7:0]      seq_hi_reg, seq_hi_next;
    logic            ovf_reg, ovf_next;
    logic [7:0]      best_reg, best_next;
    logic [IW-1:0]   best_page_reg, best_page_next;
    logic [CW-1:0]   wp_reg, wp_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [3:0]      res_page_reg, res_page_next;
    logic [4:0]      res_seq_reg, res_seq_next;
    logic            res_found_reg, res_found_next;
    logic [3:0]      m_page_reg, m_page_next;
    logic [4:0]      m_seq_reg, m_seq_next;
    logic            m_found_reg, m_found_next;

    logic [7:0]      pg8;
    logic [IW-1:0]   pg_idx;
    logic            pg_ok;
    logic            skip_go;
    logic            walk_go;

    assign pg8    = {4'b0000, s_page};
    assign pg_idx = pg8[IW-1:0];
    assign pg_ok  = (pg8 < P8);

    assign skip_go = (wp_reg < P_C) && bad_reg[wp_reg[IW-1:0]] && (cnt_reg != '0);
    assign walk_go = !valid_reg[wp_reg[IW-1:0]] && (cnt_reg != '0);

    assign st.scan_last = (idx_reg == LAST_C);
    assign st.free_hit  = free_hit_next;
    assign st.new_last  = (idx_reg == P_C);
    assign st.skip_done = !skip_go;
    assign st.walk_done = !walk_go;

    assign m_chosen_page = m_page_reg;
    assign m_slot_seq    = m_seq_reg;
    assign m_found       = m_found_reg;

    always_comb begin
        logic [IW-1:0] cur;
        logic [8:0]    sum9;
        logic          ov;
        logic [CW-1:0] w1;
        logic [CW-1:0] wpf;
        logic [7:0]    ext8;

        cur  = idx_reg[IW-1:0];
        sum9 = '0;
        ov   = 1'b0;
        w1   = wp_reg + 1'b1;
        wpf  = wp_reg;
        ext8 = '0;

        valid_next     = valid_reg;
        bad_next       = bad_reg;
        idx_next       = idx_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        any_next       = any_reg;
        free_hit_next  = free_hit_reg;
        free_idx_next  = free_idx_reg;
        write_next     = write_reg;
        seq_lo_next    = seq_lo_reg;
        seq_hi_next    = seq_hi_reg;
        ovf_next       = ovf_reg;
        best_next      = best_reg;
        best_page_next = best_page_reg;
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        res_page_next  = res_page_reg;
        res_seq_next   = res_seq_reg;
        res_found_next = res_found_reg;
        m_page_next    = m_page_reg;
        m_seq_next     = m_seq_reg;
        m_found_next   = m_found_reg;
        mem_we         = 1'b0;
        rd_addr        = lo_reg;

        case (cmd.op)
            DP_LOAD: begin
                if (pg_ok) begin
                    valid_next[pg_idx] = s_crc_good;
                    mem_we             = 1'b1;
                end
            end
            DP_MARK: begin
                if (pg_ok) begin
                    bad_next[pg_idx] = 1'b1;
                end
            end
            DP_START: begin
                idx_next      = '0;
                any_next      = 1'b0;
                lo_next       = '0;
                hi_next       = '0;
                free_hit_next = 1'b0;
                free_idx_next = '0;
                write_next    = cmd.write;
            end
            DP_SCAN: begin
                if (valid_reg[cur]) begin
                    if (!any_reg) begin
                        lo_next = cur;
                    end
                    any_next = 1'b1;
                    hi_next  = cur;
                end
                if (!free_hit_reg && !valid_reg[cur] && !bad_reg[cur]) begin
                    free_hit_next = 1'b1;
                    free_idx_next = cur;
                end
                idx_next = idx_reg + 1'b1;
            end
            DP_FREE_RD: begin
                rd_addr = free_idx_reg - 1'b1;
            end
            DP_FREE_CALC: begin
                if (free_idx_reg != '0) begin
                    sum9 = {1'b0, rd_data_reg} + 9'd1;
                    if (sum9 >= P2_9) begin
                        sum9 = 9'(free_idx_reg);
                    end
                end
                ext8           = 8'(free_idx_reg);
                res_page_next  = ext8[3:0];
                res_seq_next   = sum9[4:0];
                res_found_next = 1'b1;
            end
            DP_RD_LO: begin
                rd_addr = lo_reg;
            end
            DP_RD_HI: begin
                rd_addr     = hi_reg;
                seq_lo_next = rd_data_reg;
            end
            DP_OVF: begin
                seq_hi_next = rd_data_reg;
                ov = (rd_data_reg < seq_lo_reg);
                if (!write_reg && ({1'b0, seq_lo_reg} == 9'(lo_reg) + P9)
                        && ({1'b0, rd_data_reg} == 9'(hi_reg) + P9)) begin
                    ov = 1'b1;
                end
                ovf_next       = ov;
                best_next      = '0;
                best_page_next = '0;
                idx_next       = '0;
            end
            DP_NEW: begin
                rd_addr = cur;
                if (idx_reg != '0) begin
                    if (!bad_reg[rd_idx_reg] && (rd_data_reg > best_reg)
                            && (ovf_reg || ({1'b0, rd_data_reg} < P9))) begin
                        best_next      = rd_data_reg;
                        best_page_next = rd_idx_reg;
                    end
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == P_C) begin
                    wp_next  = CW'(best_page_next) + CW'(write_reg);
                    cnt_next = P_C;
                end
            end
            DP_SKIP: begin
                if (skip_go) begin
                    if (w1 >= P_C) begin
                        wp_next  = '0;
                        ovf_next = !ovf_reg;
                    end else begin
                        wp_next = w1;
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            DP_WFIN: begin
                if (wp_reg >= P_C) begin
                    wpf = wp_reg - P_C;
                end
                if (({1'b0, seq_lo_reg} == P9) && ({1'b0, seq_hi_reg} == P2M1_9)) begin
                    wpf = CW'(lo_reg);
                end
                sum9           = 9'(wpf) + (ovf_reg ? P9 : 9'd0);
                ext8           = 8'(wpf);
                res_page_next  = ext8[3:0];
                res_seq_next   = sum9[4:0];
                res_found_next = !bad_reg[wpf[IW-1:0]];
            end
            DP_WALK: begin
                if (walk_go) begin
                    wp_next  = (wp_reg == '0) ? LAST_C : wp_reg - 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    ext8         = 8'(wp_reg);
                    res_seq_next = '0;
                    if (cnt_reg == '0) begin
                        res_page_next  = '0;
                        res_found_next = 1'b0;
                    end else begin
                        res_page_next  = ext8[3:0];
                        res_found_next = 1'b1;
                    end
                end
            end
            DP_OUT: begin
                m_page_next  = res_page_reg;
                m_seq_next   = res_seq_reg;
                m_found_next = res_found_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            seq_mem[pg_idx] <= s_header_seq;
        end
        rd_data_reg <= seq_mem[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            bad_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            bad_reg   <= bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        any_reg       <= any_next;
        free_hit_reg  <= free_hit_next;
        free_idx_reg  <= free_idx_next;
        write_reg     <= write_next;
        seq_lo_reg    <= seq_lo_next;
        seq_hi_reg    <= seq_hi_next;
        ovf_reg       <= ovf_next;
        best_reg      <= best_next;
        best_page_reg <= best_page_next;
        wp_reg        <= wp_next;
        cnt_reg       <= cnt_next;
        res_page_reg  <= res_page_next;
        res_seq_reg   <= res_seq_next;
        res_found_reg <= res_found_next;
        m_page_reg    <= m_page_next;
        m_seq_reg     <= m_seq_next;
        m_found_reg   <= m_found_next;
    end

endmodule
